[rtl/itra_pkg.sv]
// itra_pkg: shared constants and a helper for the integer to radix ascii core
// no dependencies; used by integer_to_radix_ascii_core

package itra_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int DIGIT_DEPTH = 64;
	localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);

	localparam logic [5:0] RADIX_MIN  = 6'd2;
	localparam logic [5:0] RADIX_MAX  = 6'd36;
	localparam logic [7:0] MINUS_CHAR = 8'h2d;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] ALPHA_CHAR = 8'h61;

	// digit value to ascii, lower-case letters from ten to 35; larger values give the zero character
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] c;
		if (d < 6'd10) begin
			c = ZERO_CHAR + {2'b00, d};
		end else if (d < RADIX_MAX) begin
			c = ALPHA_CHAR + {2'b00, d} - 8'd10;
		end else begin
			c = ZERO_CHAR;
		end
		return c;
	endfunction

endpackage

[rtl/integer_to_radix_ascii_core.sv]
// integer_to_radix_ascii_core: converts one integer per request into ascii digits
// depends on itra_pkg for widths, character codes and the digit lookup
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, number, radix,        | into core
//          | is_signed                                 |
//  out     | out_valid, out_ready, character, last,    | out of core
//          | char_count, bad_radix                     |
//
// each digit comes from a full division of the working value by the base in the shared
// restoring compare/subtract unit, one quotient bit per cycle
// emission then reads the digit store and loads each character in turn, after a
// sign for a negative value; a bad base gives its single error result directly
// arst_n clears all control state; the digit store has no reset
// a new request is taken only when the core is idle; a stalled output holds
// the sequencer until out_ready

module integer_to_radix_ascii_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [itra_pkg::VALUE_WIDTH-1:0]     number,
	input  logic [5:0]                           radix,
	input  logic                                 is_signed,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           character,
	output logic                                 last,
	output logic [6:0]                           char_count,
	output logic                                 bad_radix
);

	localparam int VW = itra_pkg::VALUE_WIDTH;
	localparam int CW = itra_pkg::BIT_CNT_W;
	localparam int AW = itra_pkg::DIGIT_AW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_BAD  = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]    state_q;
	logic [VW-1:0] work_q;
	logic [5:0]    rem_q;
	logic [5:0]    radix_q;
	logic          neg_q;
	logic [CW-1:0] bit_cnt_q;
	logic [6:0]    total_q;
	logic [AW-1:0] idx_q;
	logic [6:0]    sent_q;

	logic [5:0]    digit_store [itra_pkg::DIGIT_DEPTH];
	logic [5:0]    rd_data_q;

	logic          out_valid_q;
	logic [7:0]    char_q;
	logic          last_q;
	logic [6:0]    count_q;
	logic          bad_q;

	logic          accept;
	logic          out_free;
	logic          out_load;
	logic          bad_in;
	logic          neg_in;
	logic [VW-1:0] num_in;
	logic [6:0]    trial;
	logic          ge;
	logic [5:0]    rem_next;
	logic [VW-1:0] work_next;
	logic          div_last_bit;
	logic          digits_done;
	logic          emit_last;
	logic [6:0]    char_total;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free &&
		((state_q == ST_BAD) || (state_q == ST_SIGN) || (state_q == ST_EMIT));

	assign num_in = number[VW-1:0];
	assign bad_in = (radix < itra_pkg::RADIX_MIN) || (radix > itra_pkg::RADIX_MAX);
	assign neg_in = is_signed && num_in[VW-1];

	// shared restoring divide step: one quotient bit per cycle
	assign trial     = {rem_q, work_q[VW-1]};
	assign ge        = (trial >= {1'b0, radix_q});
	assign rem_next  = ge ? 6'(trial - {1'b0, radix_q}) : trial[5:0];
	assign work_next = {work_q[VW-2:0], ge};

	assign div_last_bit = (bit_cnt_q == CW'(VW - 1));
	assign digits_done  = (work_next == '0) || (total_q == 7'(itra_pkg::DIGIT_DEPTH - 1));

	assign char_total = total_q + {6'd0, neg_q};
	// output is cut at DIGIT_DEPTH characters when a sign pushes past it
	assign emit_last  = (idx_q == '0) || (sent_q == 7'(itra_pkg::DIGIT_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			sent_q      <= '0;
			neg_q       <= 1'b0;
			work_q      <= '0;
			rem_q       <= '0;
			radix_q     <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						radix_q   <= radix;
						neg_q     <= neg_in;
						work_q    <= neg_in ? (~num_in + VW'(1)) : num_in;
						rem_q     <= '0;
						bit_cnt_q <= '0;
						total_q   <= '0;
						sent_q    <= '0;
						state_q   <= bad_in ? ST_BAD : ST_DIV;
					end
				end
				ST_DIV: begin
					bit_cnt_q <= bit_cnt_q + CW'(1);
					if (div_last_bit) begin
						total_q <= total_q + 7'd1;
						rem_q   <= '0;
						work_q  <= work_next;
						idx_q   <= total_q[AW-1:0];
						if (digits_done) begin
							state_q <= neg_q ? ST_SIGN : ST_RD;
						end
					end else begin
						rem_q  <= rem_next;
						work_q <= work_next;
					end
				end
				ST_BAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						sent_q  <= 7'd1;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						sent_q  <= sent_q + 7'd1;
						idx_q   <= idx_q - AW'(1);
						state_q <= emit_last ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digit store and its registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_last_bit) begin
			digit_store[total_q[AW-1:0]] <= rem_next;
		end
		rd_data_q <= digit_store[idx_q];
	end

	// output payload register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_BAD: begin
				if (out_free) begin
					char_q  <= 8'd0;
					last_q  <= 1'b1;
					count_q <= 7'd0;
					bad_q   <= 1'b1;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					char_q  <= itra_pkg::MINUS_CHAR;
					last_q  <= 1'b0;
					count_q <= 7'd0;
					bad_q   <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					char_q  <= itra_pkg::digit_char(rd_data_q);
					last_q  <= emit_last;
					count_q <= emit_last ? char_total : 7'd0;
					bad_q   <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign last       = last_q;
	assign char_count = count_q;
	assign bad_radix  = bad_q;

endmodule
